@@ rtl/rorr_pkg.sv @@
// Shared constants, payload types and helpers for the refraction direction core.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package rorr_pkg;

  localparam int FRAC_BITS = 14;

  // refraction index register, unsigned Q3.12
  localparam int            IDX_W     = 15;
  localparam logic [14:0]   IDX_MIN   = 15'd4096;
  localparam logic [14:0]   IDX_MAX   = 15'd16384;
  localparam logic [14:0]   IDX_RESET = 15'd6144;
  localparam logic          ADDR_REFR = 1'b0;

  // eta, unsigned with 16 fraction bits
  localparam int ETA_W      = 19;
  localparam int ETAP_W     = 17;
  localparam int ETA_NUM_W  = 29;
  localparam int ETA_CNT_W  = $clog2(ETA_NUM_W);

  // square root unit
  localparam int RAD_W      = 40;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_STEPS   = 4;
  localparam int SQ_STAGES  = ROOT_W / SQ_STEPS;

  // weight divider
  localparam int W_W        = 16;
  localparam int DV_STEPS   = 4;
  localparam int DV_STAGES  = W_W / DV_STEPS;
  localparam logic [16:0] DV_REM0 = 17'(64'd1 << (FRAC_BITS + 8 - W_W));

  typedef struct packed {
    logic signed [17:0] ix;
    logic signed [17:0] iy;
    logic signed [15:0] z;
    logic               tir;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [RAD_W-1:0]   rad;
  } sq_in_t;

  typedef struct packed {
    side_t              side;
    logic [ROOT_W-1:0]  root;
  } sq_out_t;

  typedef struct packed {
    logic signed [17:0] ix;
    logic signed [17:0] iy;
    logic signed [15:0] iz;
    logic               tir;
    logic [16:0]        az;
    logic               satw;
    logic [16:0]        rem;
    logic [W_W-1:0]     quo;
  } rcp_t;

  function automatic logic [14:0] clamp_index(input logic [14:0] v);
    logic [14:0] r;
    if (v < IDX_MIN) r = IDX_MIN;
    else if (v > IDX_MAX) r = IDX_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
    logic signed [17:0] r;
    if (v > 21'sd131071) r = 18'sd131071;
    else if (v < -21'sd131072) r = -18'sd131072;
    else r = v[17:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) r = 16'sd32767;
    else if (v < -21'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rorr_eta_div.sv @@
// Serial divider that forms eta = round(1/index) with 16 fraction bits.
// Runs after reset and after each start request; uses rorr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rorr_eta_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rorr_pkg::IDX_W-1:0]   n,
  output logic [rorr_pkg::ETAP_W-1:0]       eta_pos,
  output logic                              busy
);

  logic                               pend_r;
  logic                               run_r;
  logic [rorr_pkg::ETA_CNT_W-1:0]     cnt_r;
  logic [rorr_pkg::ETA_NUM_W-1:0]     quo_r;
  logic [15:0]                        rem_r;
  logic [15:0]                        trial;
  logic                               qbit;
  logic [15:0]                        rem_nxt;

  always_comb begin
    trial   = {rem_r[14:0], quo_r[rorr_pkg::ETA_NUM_W-1]};
    qbit    = trial >= {1'b0, n};
    rem_nxt = qbit ? trial - {1'b0, n} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
    end else if (pend_r) begin
      pend_r <= 1'b0;
      run_r  <= 1'b1;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == rorr_pkg::ETA_CNT_W'(rorr_pkg::ETA_NUM_W - 1)) run_r <= 1'b0;
    end
  end

  // numerator is 2^28 plus half the index for rounding
  always_ff @(posedge clk) begin
    if (pend_r) begin
      quo_r <= (rorr_pkg::ETA_NUM_W'(1) << (rorr_pkg::ETA_NUM_W - 1))
             + rorr_pkg::ETA_NUM_W'(n >> 1);
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[rorr_pkg::ETA_NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign eta_pos = quo_r[rorr_pkg::ETAP_W-1:0];
  assign busy    = pend_r | run_r;

endmodule

`default_nettype wire

@@ rtl/rorr_front.sv @@
// Front pipeline: eta select, z squared, eta squared, radicand and scaled x/y.
// Four stages with per-stage valid; uses rorr_pkg types and helpers.
`timescale 1ns / 1ps
`default_nettype none

module rorr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [15:0]            x,
  input  wire logic signed [15:0]            y,
  input  wire logic signed [15:0]            z,
  input  wire logic [rorr_pkg::ETAP_W-1:0]   eta_pos,
  input  wire logic [rorr_pkg::IDX_W-1:0]    n,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rorr_pkg::sq_in_t                   out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic signed [15:0]            x1_r, y1_r, z1_r;
  logic [rorr_pkg::ETA_W-1:0]    eta1_r;
  logic [30:0]                   zsq1_r;
  // stage 2
  logic signed [17:0]            mx2_r, my2_r;
  logic signed [15:0]            z2_r;
  logic                          xn2_r, yn2_r, mneg2_r;
  logic [15:0]                   mabs2_r;
  logic [37:0]                   e2_2_r;
  logic [34:0]                   px2_r, py2_r;
  // stage 3
  logic signed [17:0]            ix3_r, iy3_r, mx3_r, my3_r;
  logic signed [15:0]            z3_r;
  logic                          mneg3_r;
  logic [53:0]                   prod3_r;
  // stage 4
  rorr_pkg::sq_in_t              d4_r;

  always_comb begin
    rdy4 = !v4_r || out_ready;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
  end
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: pick eta by the side of z, square z
  logic signed [31:0] zsq_full;
  assign zsq_full = z * z;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r   <= x;
      y1_r   <= y;
      z1_r   <= z;
      eta1_r <= z[15] ? {n, 4'b0000} : {2'b00, eta_pos};
      zsq1_r <= zsq_full[30:0];
    end
  end

  // stage 2: m = 1 - z^2, eta^2, eta*|x|, eta*|y|
  logic [31:0]        zr;
  logic [16:0]        zz;
  logic signed [17:0] m;
  logic [15:0]        xa, ya;
  logic signed [16:0] xe, ye;
  logic signed [17:0] x18, y18;

  always_comb begin
    zr  = {1'b0, zsq1_r} + 32'(64'd1 << (rorr_pkg::FRAC_BITS - 1));
    zz  = 17'(zr >> rorr_pkg::FRAC_BITS);
    m   = 18'(64'd1 << rorr_pkg::FRAC_BITS) - $signed({1'b0, zz});
    xe  = 17'(x1_r);
    ye  = 17'(y1_r);
    xa  = 16'(x1_r[15] ? -xe : xe);
    ya  = 16'(y1_r[15] ? -ye : ye);
    x18 = 18'(x1_r);
    y18 = 18'(y1_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mx2_r   <= -x18;
      my2_r   <= -y18;
      z2_r    <= z1_r;
      xn2_r   <= x1_r[15];
      yn2_r   <= y1_r[15];
      mneg2_r <= m[17];
      mabs2_r <= 16'(m[17] ? -m : m);
      e2_2_r  <= eta1_r * eta1_r;
      px2_r   <= eta1_r * xa;
      py2_r   <= eta1_r * ya;
    end
  end

  // stage 3: eta^2 * |m|, round and saturate the scaled x and y
  logic [34:0]        rx, ry;
  logic [19:0]        qx, qy;
  logic signed [20:0] sx, sy;

  always_comb begin
    rx = px2_r + 35'd32768;
    ry = py2_r + 35'd32768;
    qx = 20'(rx >> 16);
    qy = 20'(ry >> 16);
    sx = xn2_r ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
    sy = yn2_r ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ix3_r   <= rorr_pkg::sat18(sx);
      iy3_r   <= rorr_pkg::sat18(sy);
      mx3_r   <= mx2_r;
      my3_r   <= my2_r;
      z3_r    <= z2_r;
      mneg3_r <= mneg2_r;
      prod3_r <= e2_2_r * mabs2_r;
    end
  end

  // stage 4: radicand, reflection test, pick mirror or refracted x/y
  logic [54:0]        pr;
  logic [21:0]        rmag;
  logic signed [23:0] re;
  logic signed [23:0] delta;
  logic               tir;

  always_comb begin
    pr    = {1'b0, prod3_r} + 55'(64'd1 << 31);
    rmag  = 22'(pr >> 32);
    re    = mneg3_r ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
    delta = 24'(64'd1 << rorr_pkg::FRAC_BITS) - re;
    tir   = delta[23];
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      d4_r.side.ix  <= tir ? mx3_r : ix3_r;
      d4_r.side.iy  <= tir ? my3_r : iy3_r;
      d4_r.side.z   <= z3_r;
      d4_r.side.tir <= tir;
      d4_r.rad      <= tir ? '0
                     : (rorr_pkg::RAD_W'($unsigned(delta)) << rorr_pkg::FRAC_BITS);
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

endmodule

`default_nettype wire

@@ rtl/rorr_sqrt.sv @@
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// Carries the side payload alongside; uses rorr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rorr_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rorr_pkg::sq_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rorr_pkg::sq_out_t       out_data
);

  localparam int NS = rorr_pkg::SQ_STAGES;
  localparam int RW = rorr_pkg::ROOT_W;
  localparam int DW = rorr_pkg::RAD_W;

  logic                  v_r    [NS];
  logic                  rdy    [NS];
  logic [23:0]           rem_r  [NS];
  logic [RW-1:0]         root_r [NS];
  logic [DW-1:0]         rad_r  [NS];
  rorr_pkg::side_t       side_r [NS];

  logic [23:0]           rem_c  [NS];
  logic [RW-1:0]         root_c [NS];
  logic [DW-1:0]         rad_c  [NS];

  always_comb begin
    for (int s = NS - 1; s >= 0; s--) begin
      if (s == NS - 1) rdy[s] = !v_r[s] || out_ready;
      else             rdy[s] = !v_r[s] || rdy[s+1];
    end
  end
  assign in_ready = rdy[0];

  always_comb begin
    logic [23:0]   rm;
    logic [RW-1:0] rt;
    logic [DW-1:0] rd;
    logic [23:0]   tr;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rm = '0;
        rt = '0;
        rd = in_data.rad;
      end else begin
        rm = rem_r[s-1];
        rt = root_r[s-1];
        rd = rad_r[s-1];
      end
      for (int i = 0; i < rorr_pkg::SQ_STEPS; i++) begin
        rm = {rm[21:0], rd[DW-1:DW-2]};
        rd = {rd[DW-3:0], 2'b00};
        tr = 24'({rt, 2'b01});
        if (rm >= tr) begin
          rm = rm - tr;
          rt = {rt[RW-2:0], 1'b1};
        end else begin
          rt = {rt[RW-2:0], 1'b0};
        end
      end
      rem_c[s]  = rm;
      root_c[s] = rt;
      rad_c[s]  = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= (s == 0) ? in_valid : v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_c[s];
        root_r[s] <= root_c[s];
        rad_r[s]  <= rad_c[s];
        side_r[s] <= (s == 0) ? in_data.side : side_r[s-1];
      end
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_data.side = side_r[NS-1];
  assign out_data.root = root_r[NS-1];

endmodule

`default_nettype wire

@@ rtl/rorr_recip.sv @@
// Output pipeline: signed and saturated z, then 2^(F+8)/|z| by staged division.
// Last stage is the result register; uses rorr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rorr_recip (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rorr_pkg::sq_out_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      res_ix,
  output logic signed [17:0]      res_iy,
  output logic signed [15:0]      res_iz,
  output logic                    res_tir,
  output logic [rorr_pkg::W_W-1:0] res_weight
);

  localparam int NS = rorr_pkg::DV_STAGES + 1;

  logic            v_r [NS];
  logic            rdy [NS];
  rorr_pkg::rcp_t  st_r [NS];
  rorr_pkg::rcp_t  st_c [NS];

  always_comb begin
    for (int s = NS - 1; s >= 0; s--) begin
      if (s == NS - 1) rdy[s] = !v_r[s] || out_ready;
      else             rdy[s] = !v_r[s] || rdy[s+1];
    end
  end
  assign in_ready = rdy[0];

  always_comb begin
    logic signed [20:0] se;
    logic signed [15:0] iz;
    logic signed [16:0] ize;
    logic [16:0]        az;
    logic [16:0]        tr;
    rorr_pkg::rcp_t     c;
    // first stage: in_z and its magnitude
    se  = $signed({1'b0, in_data.root});
    iz  = in_data.side.tir ? in_data.side.z
        : rorr_pkg::sat16(in_data.side.z[15] ? se : -se);
    ize = 17'(iz);
    az  = 17'(iz[15] ? -ize : ize);
    c.ix   = in_data.side.ix;
    c.iy   = in_data.side.iy;
    c.iz   = iz;
    c.tir  = in_data.side.tir;
    c.az   = az;
    c.satw = az <= rorr_pkg::DV_REM0;
    c.rem  = rorr_pkg::DV_REM0;
    c.quo  = '0;
    st_c[0] = c;
    // later stages: a few quotient bits each
    for (int s = 1; s < NS; s++) begin
      c = st_r[s-1];
      for (int i = 0; i < rorr_pkg::DV_STEPS; i++) begin
        tr = {c.rem[15:0], 1'b0};
        if (tr >= c.az) begin
          c.rem = tr - c.az;
          c.quo = {c.quo[rorr_pkg::W_W-2:0], 1'b1};
        end else begin
          c.rem = tr;
          c.quo = {c.quo[rorr_pkg::W_W-2:0], 1'b0};
        end
      end
      st_c[s] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= (s == 0) ? in_valid : v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) st_r[s] <= st_c[s];
    end
  end

  assign out_valid  = v_r[NS-1];
  assign res_ix     = st_r[NS-1].ix;
  assign res_iy     = st_r[NS-1].iy;
  assign res_iz     = st_r[NS-1].iz;
  assign res_tir    = st_r[NS-1].tir;
  assign res_weight = st_r[NS-1].satw ? '1 : st_r[NS-1].quo;

endmodule

`default_nettype wire

@@ rtl/refract_or_reflect_direction_core.sv @@
// Top level of the refraction direction core: register port, eta divider, pipeline.
// Instantiates rorr_eta_div, rorr_front, rorr_sqrt and rorr_recip; uses rorr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Refracts an outgoing shading-space direction (signed Q2.14) by Snell's law, with the
// refraction index taken from the register at address 0 (unsigned Q3.12, clamped to
// 1.0..4.0). Under total internal reflection the mirror direction comes back with the
// flag in out_tuser set. The weight 1/|in_z| (unsigned Q8.8) saturates at 0xFFFF.
// Throughput is one beat per cycle while out_tready is high and the eta divider is idle;
// a beat passes 4 front stages, 5 square-root stages and 5 weight-divider stages, and
// waits in place while out_tready is low. The reciprocal of the index is formed by a
// one-bit-per-cycle divider after reset and after every register-port write, and
// in_tready stays low while it runs. The result register is the last pipeline stage,
// and bubbles upstream of a held result still take new beats.
module refract_or_reflect_direction_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // out_x[15:0], out_y[31:16], out_z[47:32]
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata,  // in_x[17:0], in_y[35:18], in_z[51:36],
                                        // weight[67:52], zero[71:68]
  output logic [0:0]        out_tuser,  // total_reflection[0]
  // register port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [0:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [rorr_pkg::IDX_W-1:0]   idx_r;
  logic [rorr_pkg::IDX_W-1:0]   n_clamp;
  logic                         cfg_wr;
  logic [rorr_pkg::ETAP_W-1:0]  eta_pos;
  logic                         eta_busy;

  logic                         fr_in_ready;
  logic                         fr_valid, sq_in_ready;
  rorr_pkg::sq_in_t             fr_data;
  logic                         sq_valid, rc_in_ready;
  rorr_pkg::sq_out_t            sq_data;

  logic signed [17:0]           res_ix, res_iy;
  logic signed [15:0]           res_iz;
  logic                         res_tir;
  logic [rorr_pkg::W_W-1:0]     res_weight;

  // register port: writes land on the access phase, reads return the raw index
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == rorr_pkg::ADDR_REFR) ? 32'(idx_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= rorr_pkg::IDX_RESET;
    end else if (cfg_wr && cfg_paddr == rorr_pkg::ADDR_REFR) begin
      idx_r <= cfg_pwdata[rorr_pkg::IDX_W-1:0];
    end
  end

  assign n_clamp = rorr_pkg::clamp_index(idx_r);

  // reciprocal of the index for directions on the positive side
  rorr_eta_div u_eta_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr),
    .n       (n_clamp),
    .eta_pos (eta_pos),
    .busy    (eta_busy)
  );

  // hold off input beats while eta is being formed
  assign in_tready = fr_in_ready & ~eta_busy;

  rorr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid & ~eta_busy),
    .in_ready  (fr_in_ready),
    .x         (in_tdata[15:0]),
    .y         (in_tdata[31:16]),
    .z         (in_tdata[47:32]),
    .eta_pos   (eta_pos),
    .n         (n_clamp),
    .out_valid (fr_valid),
    .out_ready (sq_in_ready),
    .out_data  (fr_data)
  );

  rorr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (sq_in_ready),
    .in_data   (fr_data),
    .out_valid (sq_valid),
    .out_ready (rc_in_ready),
    .out_data  (sq_data)
  );

  rorr_recip u_recip (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sq_valid),
    .in_ready   (rc_in_ready),
    .in_data    (sq_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .res_ix     (res_ix),
    .res_iy     (res_iy),
    .res_iz     (res_iz),
    .res_tir    (res_tir),
    .res_weight (res_weight)
  );

  // pack the result beat
  assign out_tdata = {4'b0000, res_weight, res_iz, res_iy, res_ix};
  assign out_tuser = res_tir;

`ifndef SYNTHESIS
  a_ready_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !eta_busy)
    else $error("input taken while eta divider busy");

  a_write_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_tready)
    else $error("input ready straight after index write");

  a_zero_z_weight : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[51:36] == 16'd0) |-> out_tdata[67:52] == 16'hFFFF)
    else $error("zero in_z without saturated weight");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/sv/refract_or_reflect_direction_core_tb.sv @@
// Self-checking bench for the refraction direction core: directed table, then random beats,
// with an internal predictor of Snell refraction and total internal reflection.
// Depends on rorr_pkg and refract_or_reflect_direction_core.
`timescale 1ns / 1ps

module refract_or_reflect_direction_core_tb;

  typedef struct packed {
    logic signed [17:0] ix;
    logic signed [17:0] iy;
    logic signed [15:0] iz;
    logic               tir;
    logic [15:0]        weight;
  } dir_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               chk;  // typed-in expectation present
    dir_t               exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  refract_or_reflect_direction_core DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  logic [14:0] index_reg;
  dir_t        expected_dirs[$];
  int          mismatches = 0;
  int          beats_seen = 0;
  int          tir_seen = 0;
  bit          sink_stall_on = 1'b1;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // -(eta*c)/2^16, rounded half away from zero
  function automatic longint eta_scale_neg(input longint unsigned eta, input longint c);
    longint unsigned mag;
    longint q;
    mag = c < 0 ? -c : c;
    q = longint'((eta * mag + 32768) >> 16);
    return c < 0 ? q : -q;
  endfunction

  function automatic dir_t refract_dir(input logic signed [15:0] x, y, z, input logic [14:0] idx);
    longint unsigned n, eta, e2, zz, prod, rmag;
    longint one, m, r, delta, ix, iy, iz, az, s, zl;
    longint unsigned w;
    dir_t d;
    one = longint'(1) << rorr_pkg::FRAC_BITS;
    zl = z;
    n = idx < 4096 ? 4096 : (idx > 16384 ? 16384 : idx);
    eta = (zl >= 0) ? ((64'd1 << 28) + n / 2) / n : n << 4;
    e2 = eta * eta;
    zz = (longint'(zl * zl) + (64'd1 << (rorr_pkg::FRAC_BITS - 1))) >> rorr_pkg::FRAC_BITS;
    m = one - longint'(zz);
    prod = e2 * longint'(m < 0 ? -m : m);
    rmag = (prod + (64'd1 << 31)) >> 32;
    r = m < 0 ? -longint'(rmag) : longint'(rmag);
    delta = one - r;
    d.tir = delta < 0;
    if (d.tir) begin
      ix = -longint'(x);
      iy = -longint'(y);
      iz = zl;
    end else begin
      s = int_sqrt(longint'(delta) << rorr_pkg::FRAC_BITS);
      ix = clip(eta_scale_neg(eta, x), 18);
      iy = clip(eta_scale_neg(eta, y), 18);
      iz = clip(zl >= 0 ? -s : s, 16);
    end
    az = iz < 0 ? -iz : iz;
    if (az == 0) w = 65535;
    else begin
      w = (64'd1 << (rorr_pkg::FRAC_BITS + 8)) / az;
      if (w > 65535) w = 65535;
    end
    d.ix = ix[17:0];
    d.iy = iy[17:0];
    d.iz = iz[15:0];
    d.weight = w[15:0];
    return d;
  endfunction

  // Result side: random stalls, compare each beat with the oldest expectation.
  initial begin : sink
    int hold;
    dir_t got, want;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.ix = out_tdata[17:0];
        got.iy = out_tdata[35:18];
        got.iz = out_tdata[51:36];
        got.weight = out_tdata[67:52];
        got.tir = out_tuser[0];
        beats_seen++;
        if (got.tir) tir_seen++;
        if (expected_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = expected_dirs.pop_front();
          if (got !== want || out_tdata[71:68] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp ix=%0d iy=%0d iz=%0d tir=%0b w=%0d,",
                        " got ix=%0d iy=%0d iz=%0d tir=%0b w=%0d"},
                       want.ix, want.iy, want.iz, want.tir, want.weight,
                       got.ix, got.iy, got.iz, got.tir, got.weight);
          end
        end
      end
      // mostly no stall, else a short one, occasionally a long one
      hold = !sink_stall_on ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
             ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(8, 30)));
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
        @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Write the index register over the two-phase bus, then read it back.
  task automatic write_index(input logic [31:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= rorr_pkg::ADDR_REFR; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    index_reg = value[14:0];
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_paddr <= rorr_pkg::ADDR_REFR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    if (cfg_prdata[14:0] !== index_reg) begin
      mismatches++;
      if (mismatches <= 10) $display("index readback: exp %0d got %0d", index_reg, cfg_prdata);
    end
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
  endtask

  // Offer one beat; hold valid until it is taken.
  task automatic send_dir(input logic signed [15:0] x, y, z, input bit gaps);
    int gap;
    gap = !gaps ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(8, 25)));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    expected_dirs.push_back(refract_dir(x, y, z, index_reg));
    @(posedge clk iff in_tready);
  endtask

  task automatic drain();
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (k < 8) return 16'($urandom);           // any 16-bit value, out of range too
    return 16'($signed($urandom_range(0, 2048)) - 1024);  // near zero
  endfunction

  initial begin : stim
    row_t table_rows[$];
    row_t rw;
    logic [31:0] settings[6];
    logic signed [15:0] rx, ry, rz;
    int done;
    index_reg = rorr_pkg::IDX_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Exact expectations: the unit normal from both sides.
    // z = -1.0 at index 1.5: m=0, delta=1, root 1.0 positive, weight 256.
    table_rows.push_back('{16'sd0, 16'sd0, -16'sd16384, 1'b1,
                           '{18'sd0, 18'sd0, 16'sd16384, 1'b0, 16'd256}});
    table_rows.push_back('{16'sd0, 16'sd0, 16'sd16384, 1'b1,
                           '{18'sd0, 18'sd0, -16'sd16384, 1'b0, 16'd256}});
    // grazing from inside (z=-1 -> eta=1.5): total reflection, in_z=-1, weight saturates
    table_rows.push_back('{16'sd16384, 16'sd0, -16'sd1, 1'b0, '0});
    table_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b0, '0});
    table_rows.push_back('{16'sd16384, -16'sd16384, 16'sd0, 1'b0, '0});
    table_rows.push_back('{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0});
    table_rows.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0});
    table_rows.push_back('{16'sd11585, 16'sd0, -16'sd11585, 1'b0, '0});
    table_rows.push_back('{16'sd11585, 16'sd0, 16'sd11585, 1'b0, '0});
    table_rows.push_back('{-16'sd1, 16'sd1, 16'sd1, 1'b0, '0});
    table_rows.push_back('{16'sd5000, 16'sd9000, -16'sd6000, 1'b0, '0});
    table_rows.push_back('{-16'sd16384, 16'sd16384, -16'sd16384, 1'b0, '0});
    foreach (table_rows[i]) begin
      rw = table_rows[i];
      send_dir(rw.x, rw.y, rw.z, 1'b0);
      if (rw.chk && expected_dirs[$] !== rw.exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predictor disagrees with typed value", i);
      end
    end
    in_tvalid <= 1'b0;
    drain();

    // Index sweep: extremes, out-of-range values clamped, a middle one, full-width noise.
    settings = '{32'd4096, 32'd16384, 32'd0, 32'h7FFF, 32'd9000, 32'hFFFF_A123};
    done = 0;
    foreach (settings[s]) begin
      write_index(settings[s]);
      // the eta divider holds in_tready low after a write; the handshake absorbs it
      sink_stall_on = (s != 3);   // one phase with the sink always ready
      repeat (150) begin
        rx = rand_comp(); ry = rand_comp(); rz = rand_comp();
        send_dir(rx, ry, rz, s != 4);
        done++;
      end
      in_tvalid <= 1'b0;
      drain();
    end

    $display("covered %0d directed and %0d random beats over %0d index settings",
             table_rows.size(), done, 6);
    $display("%0d result beats checked, %0d of them total reflection", beats_seen, tir_seen);
    if (mismatches == 0 && expected_dirs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rorr_pkg.sv
rtl/rorr_eta_div.sv
rtl/rorr_front.sv
rtl/rorr_sqrt.sv
rtl/rorr_recip.sv
rtl/refract_or_reflect_direction_core.sv
tb/sv/refract_or_reflect_direction_core_tb.sv
